// ===== hdl/cgs_pkg.sv =====
`default_nettype none

package cgs_pkg;

   localparam int CH_COUNT   = 3;
   localparam int RAW_WIDTH  = 16;
   localparam int GAIN_WIDTH = 16;
   localparam int PROD_WIDTH = RAW_WIDTH + GAIN_WIDTH;
   localparam int QUO_BITS   = 8;
   localparam int DIV_WIDTH  = 9;

   // p / 1000 == (p >> 3) / 125; 125 is done by reciprocal, exact for p >> 3 < 2**29
   localparam int RECIP_WIDTH = 30;
   localparam int RECIP_SHIFT = 36;
   localparam logic [RECIP_WIDTH-1:0] RECIP_125 = 30'd549755814;
   localparam int SCL_WIDTH = (PROD_WIDTH - 3) + RECIP_WIDTH;
   localparam int QRAW_WIDTH = SCL_WIDTH - RECIP_SHIFT;

   // register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_RED   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_GREEN = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_BLUE  = 2'd2;

   localparam logic [GAIN_WIDTH-1:0] GAIN_RED_RESET   = 16'd210;
   localparam logic [GAIN_WIDTH-1:0] GAIN_GREEN_RESET = 16'd140;
   localparam logic [GAIN_WIDTH-1:0] GAIN_BLUE_RESET  = 16'd280;

   // corrected triple and its divisor, channel 0 is red
   typedef struct packed {
      logic [DIV_WIDTH-1:0]                    div;
      logic [CH_COUNT-1:0][RAW_WIDTH-1:0]      chan;
   } mid_item_type;

   typedef struct packed {
      logic                                    push;
      mid_item_type                            item;
   } mid_push_type;

   typedef struct packed {
      logic [CH_COUNT-1:0][QUO_BITS-1:0]       chan;
   } pix_type;

   typedef struct packed {
      logic                                    push;
      pix_type                                 pix;
   } pix_push_type;

endpackage

`default_nettype wire

// ===== hdl/cgs_queue.sv =====
`default_nettype none

// Plain synchronous queue; the writer keeps it from overflowing.
module cgs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold payload, write at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cgs_front.sv =====
`default_nettype none

// Gain registers, gain multiply, divide by 1000, saturate, peak and divisor.
module cgs_front #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]          req_raw_red,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]          req_raw_green,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]          req_raw_blue,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cgs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [cgs_pkg::GAIN_WIDTH-1:0]         csr_data,
   output cgs_pkg::mid_push_type                       mid_push,
   input  wire logic                                   mid_pop
);

   import cgs_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [GAIN_WIDTH-1:0] gain_ff [CH_COUNT];
   logic [GAIN_WIDTH-1:0] gain_in [CH_COUNT];
   logic [RAW_WIDTH-1:0]  raw [CH_COUNT];
   logic [PROD_WIDTH-1:0] prod_ff [CH_COUNT];
   logic [PROD_WIDTH-1:0] prod_in [CH_COUNT];
   logic [SCL_WIDTH-1:0]  scl_ff [CH_COUNT];
   logic [SCL_WIDTH-1:0]  scl_in [CH_COUNT];
   logic [2:0]            valid_ff, valid_in;
   mid_item_type          mid_ff, mid_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  accept;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_full  = (cnt_ff >= CW'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;

   assign raw[0] = req_raw_red;
   assign raw[1] = req_raw_green;
   assign raw[2] = req_raw_blue;

   // write gains; an index past the list is dropped
   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         gain_in[c] = gain_ff[c];
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_RED:   gain_in[0] = csr_data;
            CSR_GAIN_GREEN: gain_in[1] = csr_data;
            CSR_GAIN_BLUE:  gain_in[2] = csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= GAIN_RED_RESET;
         gain_ff[1] <= GAIN_GREEN_RESET;
         gain_ff[2] <= GAIN_BLUE_RESET;
      end else begin
         for (int c = 0; c < CH_COUNT; c++) begin
            gain_ff[c] <= gain_in[c];
         end
      end
   end

   // stage 1: raw times gain; stage 2: reciprocal of 125 on product over 8
   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         prod_in[c] = PROD_WIDTH'(raw[c]) * PROD_WIDTH'(gain_ff[c]);
         scl_in[c]  = SCL_WIDTH'(prod_ff[c][PROD_WIDTH-1:3]) * SCL_WIDTH'(RECIP_125);
      end
   end

   // stage 3: saturate, take the peak, form the divisor
   always_comb begin
      logic [QRAW_WIDTH-1:0] q;
      logic [RAW_WIDTH-1:0]  peak;
      peak = '0;
      mid_in.chan = '0;
      for (int c = 0; c < CH_COUNT; c++) begin
         q = scl_ff[c][SCL_WIDTH-1:RECIP_SHIFT];
         mid_in.chan[c] = (|q[QRAW_WIDTH-1:RAW_WIDTH]) ? '1 : q[RAW_WIDTH-1:0];
         if (mid_in.chan[c] > peak) begin
            peak = mid_in.chan[c];
         end
      end
      mid_in.div = DIV_WIDTH'(peak[RAW_WIDTH-1:8]) + 1'b1;
   end

   assign valid_in = {valid_ff[1:0], accept};

   always_ff @(posedge clock) begin
      for (int c = 0; c < CH_COUNT; c++) begin
         prod_ff[c] <= prod_in[c];
         scl_ff[c]  <= scl_in[c];
      end
      mid_ff <= mid_in;
   end

   // count items between the input and the back end's pop
   always_comb begin
      unique case ({accept, mid_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign mid_push.push = valid_ff[2];
   assign mid_push.item = mid_ff;

endmodule

`default_nettype wire

// ===== hdl/cgs_back.sv =====
`default_nettype none

// Divide each corrected channel by the divisor, one quotient bit per stage.
module cgs_back #(
   parameter int OUT_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  mid_empty,
   input  wire cgs_pkg::mid_item_type mid_item,
   output logic                       mid_pop,
   output cgs_pkg::pix_push_type      pix_push,
   input  wire logic                  rsp_done
);

   import cgs_pkg::*;

   localparam int CW = $clog2(OUT_DEPTH + 1);
   localparam int STAGES = QUO_BITS;

   typedef struct packed {
      logic [DIV_WIDTH-1:0]               div;
      logic [CH_COUNT-1:0][RAW_WIDTH-1:0] rem;
      logic [CH_COUNT-1:0][QUO_BITS-1:0]  quo;
   } div_stage_type;

   div_stage_type     stage_src [STAGES];
   div_stage_type     stage_in  [STAGES];
   div_stage_type     stage_ff  [STAGES];
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              issue;

   // take a triple only when the output queue has room for it
   assign issue   = !mid_empty && (cnt_ff < CW'(OUT_DEPTH));
   assign mid_pop = issue;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign stage_src[k].div = mid_item.div;
         assign stage_src[k].rem = mid_item.chan;
         assign stage_src[k].quo = '0;
      end else begin : g_body
         assign stage_src[k] = stage_ff[k-1];
      end

      // compare and subtract the shifted divisor for one quotient bit
      always_comb begin
         logic [RAW_WIDTH-1:0] dsh;
         dsh = RAW_WIDTH'(stage_src[k].div) << (QUO_BITS - 1 - k);
         stage_in[k] = stage_src[k];
         for (int c = 0; c < CH_COUNT; c++) begin
            if (stage_src[k].rem[c] >= dsh) begin
               stage_in[k].rem[c] = stage_src[k].rem[c] - dsh;
               stage_in[k].quo[c][QUO_BITS-1-k] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k] <= stage_in[k];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], issue};

   // count items between issue and the result transfer
   always_comb begin
      unique case ({issue, rsp_done})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign pix_push.push     = valid_ff[STAGES-1];
   assign pix_push.pix.chan = stage_ff[STAGES-1].quo;

endmodule

`default_nettype wire

// ===== hdl/color_gain_and_rgb888_scaler_core.sv =====
`default_nettype none

// Color gain and RGB888 scaler. Each raw 16-bit red, green and blue count is
// multiplied by its gain in thousandths, divided by 1000 and saturated to
// 65535; the three channels are then divided by (peak / 256 + 1) to give 8-bit
// components. One triple enters per cycle while req_full is low and one result
// leaves per cycle while popped. A lone triple passes 3 front stages (multiply,
// reciprocal multiply, peak), the triple queue, 8 back stages of one quotient
// bit each and the output queue. req_full rises when QUEUE_DEPTH triples sit
// between the input and the divider, and the divider stops issuing when
// OUT_DEPTH results are in flight or unread. Gains (index 0 red, 1 green, 2
// blue) must be written only while idle; the block does not enforce this.
// csr_ready is always high and index 3 is ignored. Both depths must be 2 or more.
module color_gain_and_rgb888_scaler_core #(
   parameter int QUEUE_DEPTH = 8,
   parameter int OUT_DEPTH   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]       req_raw_red,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]       req_raw_green,
   input  wire logic [cgs_pkg::RAW_WIDTH-1:0]       req_raw_blue,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic      [cgs_pkg::QUO_BITS-1:0]        rsp_red_out,
   output logic      [cgs_pkg::QUO_BITS-1:0]        rsp_green_out,
   output logic      [cgs_pkg::QUO_BITS-1:0]        rsp_blue_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cgs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cgs_pkg::GAIN_WIDTH-1:0]      csr_data
);

   import cgs_pkg::*;

   mid_push_type mid_push;
   mid_item_type mid_item;
   logic         mid_empty;
   logic         mid_pop;
   pix_push_type pix_push;
   pix_type      pix_head;
   logic         rsp_done;

   assign rsp_done = rsp_pop && !rsp_empty;

   cgs_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_raw_red  (req_raw_red),
      .req_raw_green(req_raw_green),
      .req_raw_blue (req_raw_blue),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mid_push     (mid_push),
      .mid_pop      (mid_pop)
   );

   cgs_queue #(
      .WIDTH($bits(mid_item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (mid_push.push),
      .push_data(mid_push.item),
      .pop      (mid_pop),
      .pop_data (mid_item),
      .empty    (mid_empty)
   );

   cgs_back #(
      .OUT_DEPTH(OUT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mid_empty(mid_empty),
      .mid_item (mid_item),
      .mid_pop  (mid_pop),
      .pix_push (pix_push),
      .rsp_done (rsp_done)
   );

   cgs_queue #(
      .WIDTH($bits(pix_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (pix_push.push),
      .push_data(pix_push.pix),
      .pop      (rsp_pop),
      .pop_data (pix_head),
      .empty    (rsp_empty)
   );

   assign rsp_red_out   = pix_head.chan[0];
   assign rsp_green_out = pix_head.chan[1];
   assign rsp_blue_out  = pix_head.chan[2];

endmodule

`default_nettype wire

// ===== hdl/cgs_checker.sv =====
`default_nettype none

// Port-level checks on the scaler core.
module cgs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_push,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_red_out,
   input wire logic [7:0] rsp_green_out,
   input wire logic [7:0] rsp_blue_out
);

   logic [15:0] outstanding_ff, outstanding_in;
   logic        in_xfer;
   logic        out_xfer;

   assign in_xfer  = req_push && !req_full;
   assign out_xfer = rsp_pop && !rsp_empty;

   // track triples accepted but not yet transferred out
   always_comb begin
      outstanding_in = outstanding_ff + 16'(in_xfer) - 16'(out_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // come out of reset empty and ready
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not empty and ready after reset");

   // never show a result that no input caused
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (outstanding_ff != 16'd0))
      else $error("result present with nothing outstanding");

   // never refuse input while nothing is in flight
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      req_full |-> (outstanding_ff != 16'd0))
      else $error("full with nothing outstanding");

   // hold a result that was not taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out)))
      else $error("waiting result changed");

endmodule

bind color_gain_and_rgb888_scaler_core cgs_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_push     (req_push),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_red_out  (rsp_red_out),
   .rsp_green_out(rsp_green_out),
   .rsp_blue_out (rsp_blue_out)
);

`default_nettype wire
